[design/cds_pkg.sv]
// cds_pkg: shared constants and card decode helpers for the card deck shuffler.
// No dependencies; used by the interfaces and card_deck_shuffler.
package cds_pkg;

  // Default deck parameters
  localparam int DECK_SIZE_DEF   = 52;
  localparam int RANDOM_BITS_DEF = 15;

  // Fixed field widths
  localparam int RAND_W = 15;
  localparam int CODE_W = 6;
  localparam int SUIT_W = 2;
  localparam int RANK_W = 4;
  localparam int POS_W  = 6;

  localparam logic [CODE_W-1:0] RANKS_PER_SUIT = CODE_W'(13);

  // Suit of a card code (code = suit*13 + rank-1), by range compare
  function automatic logic [SUIT_W-1:0] card_suit(input logic [CODE_W-1:0] code);
    logic [SUIT_W-1:0] s;
    if (code >= 3 * RANKS_PER_SUIT)      s = SUIT_W'(3);
    else if (code >= 2 * RANKS_PER_SUIT) s = SUIT_W'(2);
    else if (code >= RANKS_PER_SUIT)     s = SUIT_W'(1);
    else                                 s = SUIT_W'(0);
    return s;
  endfunction

  // Rank 1..13 of a card code
  function automatic logic [RANK_W-1:0] card_rank(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] base;
    logic [CODE_W-1:0] r;
    base = CODE_W'(card_suit(code)) * RANKS_PER_SUIT;
    r    = code - base + CODE_W'(1);
    return r[RANK_W-1:0];
  endfunction

endpackage

[design/cds_in_if.sv]
// cds_in_if: input channel carrying one random word per beat.
// Depends on cds_pkg for the field width.
interface cds_in_if;
  logic                      valid;
  logic                      ready;
  logic [cds_pkg::RAND_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

[design/cds_out_if.sv]
// cds_out_if: output channel carrying one drawn card per beat.
// Depends on cds_pkg for the field widths.
interface cds_out_if;
  logic                       valid;
  logic                       ready;
  logic [cds_pkg::SUIT_W-1:0] drawn_suit;
  logic [cds_pkg::RANK_W-1:0] drawn_rank;
  logic [cds_pkg::POS_W-1:0]  draw_position;
  logic                       last_of_deck;

  modport source (output valid, output drawn_suit, output drawn_rank,
                  output draw_position, output last_of_deck, input ready);
  modport sink   (input valid, input drawn_suit, input drawn_rank,
                  input draw_position, input last_of_deck, output ready);
endinterface

[design/cds_mod.sv]
// cds_mod: bit-serial restoring remainder, word mod divisor, one bit per cycle.
// Standalone; instantiated by card_deck_shuffler.
module cds_mod #(
  parameter int WORD_W = 15,
  parameter int CNT_W  = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [CNT_W-1:0]  rem_o
);

  localparam int BC_W = $clog2(WORD_W + 1);

  logic              busy_q;
  logic [BC_W-1:0]   bits_q;
  logic [WORD_W-1:0] word_q;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    div_ext;

  // one restoring step: shift in next word bit MSB first, subtract if it fits
  always_comb begin
    div_ext = {1'b0, divisor_i};
    trial   = {rem_q, word_q[WORD_W-1]};
    if (trial >= div_ext) rem_d = CNT_W'(trial - div_ext);
    else                  rem_d = trial[CNT_W-1:0];
  end

  assign done_o = busy_q && (bits_q == '0);
  assign rem_o  = rem_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bits_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      bits_q <= BC_W'(WORD_W);
    end else if (busy_q) begin
      if (bits_q != '0) bits_q <= bits_q - BC_W'(1);
      else              busy_q <= 1'b0;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      word_q <= word_i;
      rem_q  <= '0;
    end else if (busy_q && (bits_q != '0)) begin
      word_q <= word_q << 1;
      rem_q  <= rem_d;
    end
  end

endmodule

[design/card_deck_shuffler.sv]
// card_deck_shuffler: Fisher-Yates draw engine, one card drawn per random word.
// One random word is taken at a time (ready only in idle), and the next word is not taken
// until the drawn card has been loaded into the output register. Each draw runs the
// bit-serial remainder unit (one bit per cycle) over min(RANDOM_BITS,15) bits, then a read,
// a swap-write and a final-write (held while the output is stalled) on the single-write-port deck memory.
// Reset: deck sorted and full, no clearing pass (per-slot valid bits clear at once).
module card_deck_shuffler #(
  parameter int DECK_SIZE   = cds_pkg::DECK_SIZE_DEF,
  parameter int RANDOM_BITS = cds_pkg::RANDOM_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cds_in_if.sink     in_i,
  cds_out_if.source  out_o
);

  localparam int CNT_W  = $clog2(DECK_SIZE + 1);
  localparam int IDX_W  = $clog2(DECK_SIZE);
  localparam int USED_W = (RANDOM_BITS < cds_pkg::RAND_W) ? RANDOM_BITS : cds_pkg::RAND_W;
  localparam int CODE_W = cds_pkg::CODE_W;
  localparam int POS_W  = cds_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SWAP = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_m1;
  logic [IDX_W-1:0]     last_idx, slot_idx, slot_q;
  logic [DECK_SIZE-1:0] vld_q;
  logic                 vs_q, vl_q;
  logic [CODE_W-1:0]    rd_slot_q, rd_last_q;
  logic [CODE_W-1:0]    card_slot, card_last;
  logic [CODE_W-1:0]    deck_mem [DECK_SIZE];

  logic                 in_acc, mod_done, rd_en, mem_we, load_out, reload;
  logic [IDX_W-1:0]     wr_idx;
  logic [CODE_W-1:0]    wr_data;
  logic [CNT_W-1:0]     mod_rem;

  logic                        out_valid_q;
  logic [cds_pkg::SUIT_W-1:0]  out_suit_q;
  logic [cds_pkg::RANK_W-1:0]  out_rank_q;
  logic [POS_W-1:0]            out_pos_q;
  logic                        out_last_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // remainder unit: random word mod remaining count
  cds_mod #(
    .WORD_W (USED_W),
    .CNT_W  (CNT_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .word_i    (in_i.random_value[USED_W-1:0]),
    .divisor_i (count_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign count_m1 = count_q - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];
  assign slot_idx = mod_rem[IDX_W-1:0];

  // unwritten slots read as their sorted code
  assign card_slot = vs_q ? rd_slot_q : CODE_W'(slot_q);
  assign card_last = vl_q ? rd_last_q : CODE_W'(last_idx);

  // sequencer
  always_comb begin
    state_d  = state_q;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    wr_idx   = slot_q;
    wr_data  = card_last;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_DIV;
      S_DIV: begin
        if (mod_done) begin
          rd_en   = 1'b1;
          state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        mem_we  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        mem_we  = 1'b1;
        wr_idx  = last_idx;
        wr_data = card_slot;
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign reload = load_out && (count_q == CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // deck memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) deck_mem[wr_idx] <= wr_data;
    if (rd_en) begin
      rd_slot_q <= deck_mem[slot_idx];
      rd_last_q <= deck_mem[last_idx];
    end
  end

  // read-side payload: slot index and written flags
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      slot_q <= slot_idx;
      vs_q   <= vld_q[slot_idx];
      vl_q   <= vld_q[last_idx];
    end
  end

  // per-slot written flags and live count; reload clears them at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      count_q <= CNT_W'(DECK_SIZE);
    end else if (reload) begin
      vld_q   <= '0;
      count_q <= CNT_W'(DECK_SIZE);
    end else begin
      if (mem_we)   vld_q[wr_idx] <= 1'b1;
      if (load_out) count_q <= count_m1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (load_out)    out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_suit_q <= cds_pkg::card_suit(card_slot);
      out_rank_q <= cds_pkg::card_rank(card_slot);
      out_pos_q  <= POS_W'(CNT_W'(DECK_SIZE) - count_q);
      out_last_q <= (count_q == CNT_W'(1));
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.drawn_suit    = out_suit_q;
  assign out_o.drawn_rank    = out_rank_q;
  assign out_o.draw_position = out_pos_q;
  assign out_o.last_of_deck  = out_last_q;

  // checks
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_pos_q == POS_W'(DECK_SIZE - 1))
    else $error("last draw flagged at wrong position");

  a_slot_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWAP |-> slot_q <= last_idx)
    else $error("selected slot outside live deck");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reload |=> count_q == CNT_W'(DECK_SIZE) && vld_q == '0)
    else $error("deck did not reload after last draw");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> count_q != '0 && count_q <= CNT_W'(DECK_SIZE))
    else $error("live count out of range at draw");

endmodule
